// ----- design/urlx_pkg.sv -----
package urlx_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] url_byte;
    logic       url_first;
    logic       scheme_cut;
    logic       run_last;
  } result_t;

  // control for the letter cell row
  typedef struct packed {
    logic load;   // cell whose index matches takes the text byte
    logic shift;  // every cell takes its upper neighbor, the top cell the text byte
  } cell_ctl_t;

  typedef enum logic [4:0] {
    M_SCAN   = 5'b00001,
    M_COLON  = 5'b00010,
    M_SLASH1 = 5'b00100,
    M_SEP    = 5'b01000,
    M_URL    = 5'b10000
  } mode_t;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_LETTERS = 7'b0000010,
    PH_COLON   = 7'b0000100,
    PH_SLASH_A = 7'b0001000,
    PH_SLASH_B = 7'b0010000,
    PH_BYTE    = 7'b0100000,
    PH_END     = 7'b1000000
  } phase_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_url_byte(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    unique case (c)
      "~", ";", "/", "?", ":", "@", "=", "&", "$", "-",
      "_", ".", "+", "!", "*", "'", "(", ")", ",": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit || is_letter(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic result_t make_result(input logic kind, input logic [7:0] b,
                                          input logic first, input logic cut,
                                          input logic last);
    result_t r;
    r.item_kind  = kind;
    r.url_byte   = b;
    r.url_first  = first;
    r.scheme_cut = cut;
    r.run_last   = last;
    return r;
  endfunction

endpackage

// ----- design/urlx_cell.sv -----
module urlx_cell
  import urlx_pkg::*;
#(
  parameter int CNT_W = 6,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] index,
  input  logic [7:0]       text_byte,
  input  logic [7:0]       nbr_byte,
  output logic [7:0]       value
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= nbr_byte;
    end else if (ctl.load && index == CNT_W'(IDX)) begin
      value <= text_byte;
    end
  end

endmodule

// ----- design/url_extractor_stream.sv -----
// URL finder over a byte stream.
// text channel: one byte per transfer (text.text_byte) with text.final_byte
// marking the last byte of the text. result channel: URL bytes in order,
// url_first on the first scheme letter, then an end marker (item_kind = 1).
// run_last flags the last result caused by one input byte.
// Scheme letters sit in a row of SCHEME_DEPTH cells; longer schemes keep the
// newest letters and set scheme_cut on every result of that URL.
// Throughput: one byte per cycle while scanning, and inside a URL while the
// result register is free; a URL byte that ends the text is followed by its end
// marker. The byte after "://" is taken, then holds the text side while its burst
// goes out: the letters drain out of cell 0 one per cycle while the result register
// is free, then ":", "/", "/", then the byte or the end marker (the byte and then
// the end marker if it is a URL byte that also ends the text).
// A transfer inside a URL loads its result into the result register as it is
// taken; the first result of the burst after "://" waits for the drain phase.
// While the result register holds an untaken transfer the block keeps taking
// text that makes no result; a byte inside a URL waits on text_ready, and the
// byte after "://" is taken at once while its burst waits on result_ready.
// Reset (rst, synchronous) empties the result register and returns to plain
// scanning with no letter run; cell contents are not cleared.
module url_extractor_stream
  import urlx_pkg::*;
#(
  parameter int SCHEME_DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    text_valid,
  output logic    text_ready,
  input  text_t   text,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int CNT_W = $clog2(SCHEME_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SCHEME_DEPTH);

  mode_t            mode, mode_next;
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] letter_count, letter_count_next;
  logic             letters_dropped, letters_dropped_next;
  logic             scheme_start, scheme_start_next;
  logic [7:0]       pend_byte, pend_byte_next;
  logic             pend_fin, pend_fin_next;
  logic             pend_url, pend_url_next;

  logic [7:0]       cell_val [SCHEME_DEPTH];
  cell_ctl_t        cell_ctl;
  logic [CNT_W-1:0] cell_index;

  logic             out_free, out_load;
  result_t          out_next;

  logic             accept, fin, c_letter, c_url;
  logic [7:0]       c;
  logic [CNT_W-1:0] eff_count;
  logic             eff_drop;

  assign c        = text.text_byte;
  assign fin      = text.final_byte;
  assign c_letter = is_letter(c);
  assign c_url    = is_url_byte(c);
  assign out_free = !result_valid || result_ready;
  assign text_ready = (phase == PH_IDLE) && (mode != M_URL || out_free);
  assign accept   = text_valid && text_ready;

  // a broken separator drops the letter run before the byte is scanned
  assign eff_count = (mode == M_SCAN) ? letter_count : '0;
  assign eff_drop  = (mode == M_SCAN) && letters_dropped;

  always_comb begin
    mode_next            = mode;
    phase_next           = phase;
    letter_count_next    = letter_count;
    letters_dropped_next = letters_dropped;
    scheme_start_next    = scheme_start;
    pend_byte_next       = pend_byte;
    pend_fin_next        = pend_fin;
    pend_url_next        = pend_url;
    out_load             = 1'b0;
    out_next             = '0;
    cell_ctl             = '0;
    cell_index           = eff_count;

    if (phase == PH_IDLE) begin
      if (accept) begin
        unique case (mode)
          M_SEP: begin
            pend_byte_next    = c;
            pend_fin_next     = fin;
            pend_url_next     = c_url;
            scheme_start_next = 1'b1;
            phase_next        = PH_LETTERS;
          end
          M_URL: begin
            out_load = 1'b1;
            if (c_url) begin
              out_next = make_result(KIND_BYTE, c, 1'b0, letters_dropped, !fin);
              if (fin) begin
                pend_fin_next = 1'b1;
                pend_url_next = 1'b1;
                phase_next    = PH_END;
              end
            end else begin
              out_next = make_result(KIND_END, 8'h00, 1'b0, letters_dropped, 1'b1);
              mode_next            = M_SCAN;
              letter_count_next    = '0;
              letters_dropped_next = 1'b0;
            end
          end
          default: begin
            if (mode == M_COLON && c == CH_SLASH) begin
              mode_next = M_SLASH1;
            end else if (mode == M_SLASH1 && c == CH_SLASH) begin
              mode_next = M_SEP;
            end else if (c_letter) begin
              mode_next = M_SCAN;
              if (eff_count < DEPTH_C) begin
                cell_ctl.load        = 1'b1;
                letter_count_next    = eff_count + CNT_W'(1);
                letters_dropped_next = eff_drop;
              end else begin
                cell_ctl.shift       = 1'b1;
                letter_count_next    = eff_count;
                letters_dropped_next = 1'b1;
              end
            end else if (c == CH_COLON && eff_count != '0) begin
              mode_next            = M_COLON;
              letter_count_next    = eff_count;
              letters_dropped_next = eff_drop;
            end else begin
              mode_next            = M_SCAN;
              letter_count_next    = '0;
              letters_dropped_next = 1'b0;
            end
            if (fin) begin
              mode_next            = M_SCAN;
              letter_count_next    = '0;
              letters_dropped_next = 1'b0;
            end
          end
        endcase
      end
    end else if (out_free) begin
      out_load = 1'b1;
      unique case (phase)
        PH_LETTERS: begin
          out_next = make_result(KIND_BYTE, cell_val[0], scheme_start,
                                 letters_dropped, 1'b0);
          scheme_start_next = 1'b0;
          cell_ctl.shift    = 1'b1;
          letter_count_next = letter_count - CNT_W'(1);
          if (letter_count == CNT_W'(1)) begin
            phase_next = PH_COLON;
          end
        end
        PH_COLON: begin
          out_next   = make_result(KIND_BYTE, CH_COLON, 1'b0, letters_dropped, 1'b0);
          phase_next = PH_SLASH_A;
        end
        PH_SLASH_A: begin
          out_next   = make_result(KIND_BYTE, CH_SLASH, 1'b0, letters_dropped, 1'b0);
          phase_next = PH_SLASH_B;
        end
        PH_SLASH_B: begin
          out_next   = make_result(KIND_BYTE, CH_SLASH, 1'b0, letters_dropped, 1'b0);
          phase_next = pend_url ? PH_BYTE : PH_END;
        end
        PH_BYTE: begin
          out_next = make_result(KIND_BYTE, pend_byte, 1'b0, letters_dropped, !pend_fin);
          if (pend_fin) begin
            phase_next = PH_END;
          end else begin
            phase_next = PH_IDLE;
            mode_next  = M_URL;
          end
        end
        PH_END: begin
          // every path here ends the run: end of text or a non-URL byte
          out_next = make_result(KIND_END, 8'h00, 1'b0, letters_dropped, 1'b1);
          phase_next           = PH_IDLE;
          mode_next            = M_SCAN;
          letter_count_next    = '0;
          letters_dropped_next = 1'b0;
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_SCAN;
      phase           <= PH_IDLE;
      letter_count    <= '0;
      letters_dropped <= 1'b0;
      scheme_start    <= 1'b0;
      pend_fin        <= 1'b0;
      pend_url        <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      mode            <= mode_next;
      phase           <= phase_next;
      letter_count    <= letter_count_next;
      letters_dropped <= letters_dropped_next;
      scheme_start    <= scheme_start_next;
      pend_fin        <= pend_fin_next;
      pend_url        <= pend_url_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    if (out_load) begin
      result <= out_next;
    end
  end

  // letter row: oldest letter in cell 0, shifts toward cell 0
  for (genvar i = 0; i < SCHEME_DEPTH; i++) begin : g_cell
    if (i == SCHEME_DEPTH - 1) begin : g_top
      urlx_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .index     (cell_index),
        .text_byte (c),
        .nbr_byte  (c),
        .value     (cell_val[i])
      );
    end else begin : g_mid
      urlx_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .index     (cell_index),
        .text_byte (c),
        .nbr_byte  (cell_val[i+1]),
        .value     (cell_val[i])
      );
    end
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LETTERS |-> letter_count != '0)
    else $error("letter drain with empty run");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.item_kind == KIND_END |-> result.run_last)
    else $error("end marker not flagged last");

  a_sep_starts_drain: assert property (@(posedge clk) disable iff (rst)
    accept && mode == M_SEP |=> phase == PH_LETTERS)
    else $error("confirmed scheme did not start drain");

  a_drop_means_full: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE && mode != M_URL && letters_dropped |-> letter_count == DEPTH_C)
    else $error("dropped letters with partial buffer");

endmodule

// ----- bench/tb_url_extractor_stream.sv -----
`timescale 1ns / 1ps

module tb_url_extractor_stream;
  import urlx_pkg::*;

  localparam int SCHEME_DEPTH = 32;
  localparam int RANDOM_ITEMS = 240;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 40;
  localparam string URL_PUNCT = "~;/?:@=&$-_.+!*'(),";

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_RESULT,
    ONE_RESULT
  } row_check_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    row_check_t chk;
    result_t    lone;
  } plan_row_t;

  localparam result_t END_ALONE = '{item_kind: KIND_END, url_byte: 8'h00, url_first: 1'b0,
                                    scheme_cut: 1'b0, run_last: 1'b1};

  localparam int PLAN_ROWS = 24;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{8'h00, 1'b0, NO_RESULT,  '0},
    '{8'hff, 1'b0, NO_RESULT,  '0},
    // separator with no scheme in front
    '{":",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"a",   1'b0, NO_RESULT,  '0},
    '{"Z",   1'b0, NO_RESULT,  '0},
    '{":",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"0",   1'b0, BY_MODEL,   '0},
    '{" ",   1'b0, ONE_RESULT, END_ALONE},
    // "k" breaks ":/" and starts a new scheme
    '{"q",   1'b0, NO_RESULT,  '0},
    '{":",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"k",   1'b0, NO_RESULT,  '0},
    '{":",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{8'h22, 1'b0, BY_MODEL,   '0},
    // text ends right after the separator
    '{"h",   1'b0, NO_RESULT,  '0},
    '{":",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b0, NO_RESULT,  '0},
    '{"/",   1'b1, NO_RESULT,  '0}
  };

  logic    clk;
  logic    rst = 1'b1;
  logic    text_valid = 1'b0;
  logic    text_ready;
  text_t   text = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  url_extractor_stream #(
    .SCHEME_DEPTH(SCHEME_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text(text),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // predictor state
  mode_t       scan_state = M_SCAN;
  int unsigned held_letters = 0;
  logic        cut_flag = 1'b0;
  logic [7:0]  scheme_buf [SCHEME_DEPTH];

  result_t url_results [$];
  result_t step_out [$];
  text_t   segment [$];

  int errors = 0;
  int result_count = 0;
  int quiet_cycles = 0;
  int tx_steady_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic bit url_char(input logic [7:0] c);
    if (letter_char(c) || (c >= 8'h30 && c <= 8'h39)) return 1'b1;
    for (int k = 0; k < URL_PUNCT.len(); k++)
      if (URL_PUNCT[k] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_run();
    held_letters = 0;
    cut_flag = 1'b0;
  endfunction

  function automatic void scan_plain(input logic [7:0] c);
    if (letter_char(c)) begin
      if (held_letters < SCHEME_DEPTH) begin
        scheme_buf[held_letters] = c;
        held_letters++;
      end else begin
        for (int k = 0; k < SCHEME_DEPTH - 1; k++) scheme_buf[k] = scheme_buf[k + 1];
        scheme_buf[SCHEME_DEPTH - 1] = c;
        cut_flag = 1'b1;
      end
      scan_state = M_SCAN;
    end else if (c == CH_COLON && held_letters > 0) begin
      scan_state = M_COLON;
    end else begin
      drop_run();
      scan_state = M_SCAN;
    end
  endfunction

  function automatic void put_result(input logic kind, input logic [7:0] b, input logic first);
    result_t r;
    r.item_kind  = kind;
    r.url_byte   = b;
    r.url_first  = first;
    r.scheme_cut = cut_flag;
    r.run_last   = 1'b0;
    step_out = {step_out, r};
  endfunction

  // results caused by one text byte land in step_out, run_last already set
  function automatic void url_scan_step(input text_t t);
    logic [7:0] c;
    result_t    r;
    c = t.text_byte;
    step_out.delete();
    case (scan_state)
      M_COLON, M_SLASH1: begin
        if (c == CH_SLASH) begin
          scan_state = (scan_state == M_COLON) ? M_SLASH1 : M_SEP;
        end else begin
          drop_run();
          scan_plain(c);
        end
      end
      M_SEP: begin
        for (int k = 0; k < held_letters; k++) put_result(KIND_BYTE, scheme_buf[k], k == 0);
        put_result(KIND_BYTE, CH_COLON, 1'b0);
        put_result(KIND_BYTE, CH_SLASH, 1'b0);
        put_result(KIND_BYTE, CH_SLASH, 1'b0);
        if (url_char(c)) begin
          put_result(KIND_BYTE, c, 1'b0);
          scan_state = M_URL;
          if (t.final_byte) put_result(KIND_END, 8'h00, 1'b0);
        end else begin
          put_result(KIND_END, 8'h00, 1'b0);
          drop_run();
          scan_plain(c);
        end
      end
      M_URL: begin
        if (url_char(c)) begin
          put_result(KIND_BYTE, c, 1'b0);
          if (t.final_byte) put_result(KIND_END, 8'h00, 1'b0);
        end else begin
          put_result(KIND_END, 8'h00, 1'b0);
          drop_run();
          scan_plain(c);
        end
      end
      default: scan_plain(c);
    endcase
    if (t.final_byte) begin
      scan_state = M_SCAN;
      drop_run();
    end
    for (int i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.run_last = (i == step_out.size() - 1);
      step_out[i] = r;
    end
  endfunction

  function automatic void queue_predicted();
    foreach (step_out[i]) url_results = {url_results, step_out[i]};
  endfunction

  function automatic int draw_gap(inout int steady_left);
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) steady_left = $urandom_range(8, 40);
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5a))
                                : 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [7:0] rand_other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (url_char(c));
    return c;
  endfunction

  // one stretch of text: mostly well-formed URLs, some broken separators, some noise
  function automatic void plan_segment();
    int    kind;
    int    n;
    bit    end_final;
    text_t t;
    kind = $urandom_range(0, 9);
    t = '0;
    if (kind < 6) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(SCHEME_DEPTH - 2, SCHEME_DEPTH + 8)
                                      : $urandom_range(1, 5);
      repeat (n) begin
        t.text_byte = rand_letter();
        segment = {segment, t};
      end
      t.text_byte = CH_COLON;
      segment = {segment, t};
      t.text_byte = CH_SLASH;
      segment = {segment, t};
      segment = {segment, t};
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: t.text_byte = 8'($urandom_range(8'h30, 8'h39));
          1: t.text_byte = URL_PUNCT[$urandom_range(0, URL_PUNCT.len() - 1)];
          default: t.text_byte = rand_letter();
        endcase
        segment = {segment, t};
      end
      if ($urandom_range(0, 1)) begin
        t.text_byte = rand_other_char();
        segment = {segment, t};
      end
    end else if (kind < 8) begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        t.text_byte = rand_letter();
        segment = {segment, t};
      end
      t.text_byte = CH_COLON;
      segment = {segment, t};
      if ($urandom_range(0, 1)) begin
        t.text_byte = CH_SLASH;
        segment = {segment, t};
      end
      t.text_byte = $urandom_range(0, 1) ? rand_other_char() : 8'($urandom_range(0, 255));
      segment = {segment, t};
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        t.text_byte = 8'($urandom_range(0, 255));
        segment = {segment, t};
      end
    end
    end_final = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < segment.size(); i++) begin
      t = segment[i];
      t.final_byte = (i == segment.size() - 1) ? end_final : ($urandom_range(0, 39) == 0);
      segment[i] = t;
    end
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= 200) $display("%0t: result transfer %0d: %s", $realtime, result_count, what);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (url_results.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing expected", got));
    end else begin
      want = url_results.pop_front();
      if (got.item_kind !== want.item_kind)
        flag_mismatch($sformatf("item_kind %b, expected %b", got.item_kind, want.item_kind));
      if (got.url_byte !== want.url_byte)
        flag_mismatch($sformatf("url_byte %h, expected %h", got.url_byte, want.url_byte));
      if (got.url_first !== want.url_first)
        flag_mismatch($sformatf("url_first %b, expected %b", got.url_first, want.url_first));
      if (got.scheme_cut !== want.scheme_cut)
        flag_mismatch($sformatf("scheme_cut %b, expected %b", got.scheme_cut, want.scheme_cut));
      if (got.run_last !== want.run_last)
        flag_mismatch($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
    end
    result_count++;
  endtask

  // returns in the time step of the transfer
  task automatic send_text(input text_t t);
    int gap;
    gap = draw_gap(tx_steady_left);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text <= t;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
  endtask

  // waits on a clock edge before each check of the queue
  task automatic wait_drained();
    do @(posedge clk); while (url_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((text_valid && text_ready) || (result_valid && result_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (result_valid && result_ready) check_result(result);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    int steady_left;
    steady_left = 0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(steady_left);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin
    text_t     t;
    plan_row_t row;
    int        random_sent;
    random_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      t.text_byte = row.ch;
      t.final_byte = row.fin;
      send_text(t);
      url_scan_step(t);
      case (row.chk)
        BY_MODEL:   queue_predicted();
        ONE_RESULT: url_results = {url_results, row.lone};
        default:    ;
      endcase
    end
    text_valid <= 1'b0;
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      plan_segment();
      while (segment.size() > 0) begin
        t = segment.pop_front();
        send_text(t);
        url_scan_step(t);
        queue_predicted();
        random_sent++;
        // hold the text side until every expected result has drained
        if (random_sent == RANDOM_ITEMS / 2) begin
          text_valid <= 1'b0;
          wait_drained();
        end
      end
    end
    text_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/urlx_pkg.sv
design/urlx_cell.sv
design/url_extractor_stream.sv
bench/tb_url_extractor_stream.sv
